FILE: rtl/core/clt_pkg.sv
// ---------------------------------------------------------------------------
// Command line tokenizer package
// Shared types, limits and role codes for the tokenizer core.
// ---------------------------------------------------------------------------
package clt_pkg;

    // Line and command limits.
    localparam int MAX_WORDS    = 16;
    localparam int MAX_COMMANDS = 8;
    localparam int LINE_LENGTH  = 256;

    // Internal counter widths follow from the limits.
    localparam int CD_W = $clog2(MAX_COMMANDS + 1);
    localparam int WC_W = $clog2(MAX_WORDS);

    // Position saturates at one less than the line length, capped by the 8-bit field.
    localparam logic [7:0] POS_LIMIT = (LINE_LENGTH - 1 > 255) ? 8'd255
                                                               : 8'(LINE_LENGTH - 1);

    // Decoupling queue depth between front and back.
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Character codes.
    localparam logic [7:0] CHAR_PIPE  = 8'h7C;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Item kind codes.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Role of each result.
    typedef enum logic [2:0] {
        ROLE_SEP        = 3'd0,
        ROLE_WORD_START = 3'd1,
        ROLE_WORD_CONT  = 3'd2,
        ROLE_PIPE       = 3'd3,
        ROLE_ERROR      = 3'd4,
        ROLE_END        = 3'd5
    } t_clt_role;

    // Classified request as it travels through the queue.
    typedef struct packed {
        logic is_end;
        logic is_blank;
        logic is_pipe;
        logic is_amp;
    } t_clt_item;

    // Queue status seen by front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_clt_qstat;

    // One result.
    typedef struct packed {
        t_clt_role  role;
        logic [7:0] position;
        logic [2:0] command_index;
        logic [3:0] word_index;
        logic       command_closed;
        logic [2:0] closed_index;
        logic [3:0] closed_word_count;
        logic       closed_background;
        logic [3:0] command_total;
        logic       line_background;
    } t_clt_result;

endpackage

FILE: rtl/core/clt_front.sv
// ---------------------------------------------------------------------------
// Tokenizer front end
// Accepts input requests and classifies each byte before queuing it.
// ---------------------------------------------------------------------------
module clt_front (
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_kind,
    input  logic [7:0]          i_char_in,
    input  clt_pkg::t_clt_qstat i_qstat,
    output logic                o_push,
    output clt_pkg::t_clt_item  o_item
);
    import clt_pkg::*;

    // A request is taken whenever the queue has room.
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // Byte classes: whitespace is tab through carriage return, and space.
    always_comb begin
        o_item.is_end   = (i_kind == KIND_END);
        o_item.is_blank = (i_char_in == CHAR_SPACE) ||
                          ((i_char_in >= CHAR_TAB) && (i_char_in <= CHAR_CR));
        o_item.is_pipe  = (i_char_in == CHAR_PIPE);
        o_item.is_amp   = (i_char_in == CHAR_AMP);
    end

endmodule

FILE: rtl/core/clt_queue.sv
// ---------------------------------------------------------------------------
// Tokenizer request queue
// Short FIFO of classified requests between the front and back ends.
// ---------------------------------------------------------------------------
module clt_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clt_pkg::t_clt_item  i_item,
    input  logic                i_pop,
    output clt_pkg::t_clt_item  o_item,
    output clt_pkg::t_clt_qstat o_qstat
);
    import clt_pkg::*;

    t_clt_item             r_mem [Q_DEPTH];
    logic [QP_W-1:0]       r_wptr, n_wptr;
    logic [QP_W-1:0]       r_rptr, n_rptr;
    logic [QC_W-1:0]       r_count, n_count;

    // Pointer and fill count updates.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_item        = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == QC_W'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

FILE: rtl/core/clt_back.sv
// ---------------------------------------------------------------------------
// Tokenizer back end
// Applies queued requests to the parser state and registers each result.
// ---------------------------------------------------------------------------
module clt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  clt_pkg::t_clt_qstat  i_qstat,
    input  clt_pkg::t_clt_item   i_item,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output clt_pkg::t_clt_result o_result
);
    import clt_pkg::*;

    logic              r_command_open,  n_command_open;
    logic [CD_W-1:0]   r_commands_done, n_commands_done;
    logic [WC_W-1:0]   r_words,         n_words;
    logic              r_inside,        n_inside;
    logic              r_lone_amp,      n_lone_amp;
    logic              r_error,         n_error;
    logic [7:0]        r_position,      n_position;
    logic              r_last_bg,       n_last_bg;
    logic              r_valid;
    t_clt_result       r_result,        n_result;

    logic              limit_hit;
    logic              close_bg;
    logic [WC_W-1:0]   close_count;
    logic [31:0]       cd_ext;
    logic [31:0]       wc_ext;

    // The output register takes a new result when empty or being drained.
    assign o_pop = (!r_valid || i_ready) && !i_qstat.empty;

    // Count and background flag of the command as it stands now.
    always_comb begin
        close_bg    = (r_words != '0) && r_lone_amp;
        close_count = r_words - WC_W'(close_bg);
    end

    // Next state and result for the request at the head of the queue.
    always_comb begin
        n_command_open  = r_command_open;
        n_commands_done = r_commands_done;
        n_words         = r_words;
        n_inside        = r_inside;
        n_lone_amp      = r_lone_amp;
        n_error         = r_error;
        n_position      = r_position;
        n_last_bg       = r_last_bg;
        n_result        = '0;
        n_result.role   = ROLE_SEP;
        n_result.position = r_position;
        limit_hit       = (32'(r_commands_done) >= MAX_COMMANDS);
        cd_ext          = 32'(r_commands_done);
        wc_ext          = 32'(close_count);

        if (i_item.is_end) begin
            // End marker: unless an error is pending, close an open command and report totals; then reset.
            n_result.role = ROLE_END;
            if (!r_error) begin
                if (r_command_open) begin
                    n_result.command_closed    = 1'b1;
                    n_result.closed_index      = cd_ext[2:0];
                    n_result.closed_word_count = wc_ext[3:0];
                    n_result.closed_background = close_bg;
                    n_result.line_background   = close_bg;
                    cd_ext = 32'(r_commands_done) + 32'd1;
                end else begin
                    n_result.line_background   = r_last_bg;
                end
                n_result.command_total = cd_ext[3:0];
            end
            n_command_open  = 1'b0;
            n_commands_done = '0;
            n_words         = '0;
            n_inside        = 1'b0;
            n_lone_amp      = 1'b0;
            n_error         = 1'b0;
            n_position      = '0;
            n_last_bg       = 1'b0;
        end else begin
            if (r_position < POS_LIMIT) begin
                n_position = r_position + 8'd1;
            end
            if (r_error || limit_hit) begin
                // Bytes after an error or past the command limit are ignored.
            end else if (i_item.is_blank) begin
                // Whitespace ends a word and opens a command if none is open.
                if (!r_command_open) begin
                    n_command_open = 1'b1;
                    n_words        = '0;
                    n_lone_amp     = 1'b0;
                end
                n_inside = 1'b0;
            end else if (i_item.is_pipe) begin
                if (r_command_open && (r_words != '0)) begin
                    n_result.role              = ROLE_PIPE;
                    n_result.command_closed    = 1'b1;
                    n_result.closed_index      = cd_ext[2:0];
                    n_result.closed_word_count = wc_ext[3:0];
                    n_result.closed_background = close_bg;
                    n_last_bg       = close_bg;
                    n_commands_done = r_commands_done + 1'b1;
                    n_command_open  = 1'b0;
                    n_inside        = 1'b0;
                    n_words         = '0;
                    n_lone_amp      = 1'b0;
                end else begin
                    n_result.role = ROLE_ERROR;
                    n_error       = 1'b1;
                end
            end else if (r_inside) begin
                // Continuation of the current word.
                n_lone_amp = 1'b0;
                wc_ext     = 32'(r_words) - 32'd1;
                n_result.role          = ROLE_WORD_CONT;
                n_result.command_index = cd_ext[2:0];
                n_result.word_index    = wc_ext[3:0];
            end else begin
                // Word start; a full command closes first.
                if (r_command_open && (32'(r_words) >= MAX_WORDS - 1)) begin
                    n_result.command_closed    = 1'b1;
                    n_result.closed_index      = cd_ext[2:0];
                    n_result.closed_word_count = wc_ext[3:0];
                    n_result.closed_background = close_bg;
                    n_last_bg       = close_bg;
                    n_commands_done = r_commands_done + 1'b1;
                    n_command_open  = 1'b0;
                    n_inside        = 1'b0;
                    n_words         = '0;
                    n_lone_amp      = 1'b0;
                end
                if (32'(n_commands_done) < MAX_COMMANDS) begin
                    n_command_open = 1'b1;
                    n_words        = n_command_open ? n_words + 1'b1 : n_words;
                    n_inside       = 1'b1;
                    n_lone_amp     = i_item.is_amp;
                    cd_ext         = 32'(n_commands_done);
                    wc_ext         = 32'(n_words) - 32'd1;
                    n_result.role          = ROLE_WORD_START;
                    n_result.command_index = cd_ext[2:0];
                    n_result.word_index    = wc_ext[3:0];
                end
            end
        end
    end

    // Parser state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command_open  <= 1'b0;
            r_commands_done <= '0;
            r_words         <= '0;
            r_inside        <= 1'b0;
            r_lone_amp      <= 1'b0;
            r_error         <= 1'b0;
            r_position      <= '0;
            r_last_bg       <= 1'b0;
            r_valid         <= 1'b0;
        end else begin
            if (o_pop) begin
                r_command_open  <= n_command_open;
                r_commands_done <= n_commands_done;
                r_words         <= n_words;
                r_inside        <= n_inside;
                r_lone_amp      <= n_lone_amp;
                r_error         <= n_error;
                r_position      <= n_position;
                r_last_bg       <= n_last_bg;
            end
            if (!r_valid || i_ready) begin
                r_valid <= !i_qstat.empty;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/core/command_line_tokenizer_core.sv
// ---------------------------------------------------------------------------
// Command line tokenizer core
// Splits a byte stream into words and piped commands, one result per request.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+----------------------------------
//   input   | in        | i_valid / o_ready  | i_kind, i_char_in
//   output  | out       | o_valid / i_ready  | o_role ... o_line_background
//
// Throughput is one request per cycle while neither side stalls. An accepted
// request is written into the queue, parsed at the queue head by the back end
// and its result is held in the output register until it is taken.
// The back end updates the parser state once for each request it pops.
// Reset is synchronous and active low; it empties the queue and parser state.
// Either side may stall: the queue absorbs up to two requests in flight.
// ---------------------------------------------------------------------------
module command_line_tokenizer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [7:0] i_char_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_role,
    output logic [7:0] o_position,
    output logic [2:0] o_command_index,
    output logic [3:0] o_word_index,
    output logic       o_command_closed,
    output logic [2:0] o_closed_index,
    output logic [3:0] o_closed_word_count,
    output logic       o_closed_background,
    output logic [3:0] o_command_total,
    output logic       o_line_background
);
    import clt_pkg::*;

    t_clt_qstat  qstat;
    t_clt_item   push_item;
    t_clt_item   head_item;
    t_clt_result result;
    logic        push;
    logic        pop;

    // Front end: accept and classify.
    clt_front u_front (
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_kind    (i_kind),
        .i_char_in (i_char_in),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_item    (push_item)
    );

    // Decoupling queue.
    clt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_qstat (qstat)
    );

    // Back end: parser state and output register.
    clt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qstat  (qstat),
        .i_item   (head_item),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    // Result fields to ports.
    assign o_role              = result.role;
    assign o_position          = result.position;
    assign o_command_index     = result.command_index;
    assign o_word_index        = result.word_index;
    assign o_command_closed    = result.command_closed;
    assign o_closed_index      = result.closed_index;
    assign o_closed_word_count = result.closed_word_count;
    assign o_closed_background = result.closed_background;
    assign o_command_total     = result.command_total;
    assign o_line_background   = result.line_background;

    // The queue is never full and empty at once.
    a_qstat_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty together");

    // A pop only happens when the queue holds a request.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from an empty queue");

    // The command total never exceeds the command limit.
    a_total_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_role == ROLE_END)) |-> (32'(o_command_total) <= MAX_COMMANDS))
        else $error("command total beyond limit");

    // An error result never closes a command.
    a_error_noclose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_role == ROLE_ERROR)) |-> !o_command_closed)
        else $error("error result closes a command");

endmodule

FILE: test/tokenizer_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tokenizer result checker
// Watches both channels of the tokenizer core. Every accepted request is run
// through a local copy of the parser to produce the expected result, which
// is queued and compared field by field with the next result that the core
// delivers. Mismatch and tally counts go back to the testbench top.
// ---------------------------------------------------------------------------
module tokenizer_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic       i_req_kind,
    input  logic [7:0] i_req_char,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [2:0] i_role,
    input  logic [7:0] i_position,
    input  logic [2:0] i_command_index,
    input  logic [3:0] i_word_index,
    input  logic       i_command_closed,
    input  logic [2:0] i_closed_index,
    input  logic [3:0] i_closed_word_count,
    input  logic       i_closed_background,
    input  logic [3:0] i_command_total,
    input  logic       i_line_background,
    output int         o_mismatches,
    output int         o_outstanding,
    output int         o_results,
    output int         o_closes,
    output int         o_background,
    output int         o_errors
);
    import clt_pkg::*;

    // Keeps a flood of mismatches from swamping the log.
    localparam int REPORT_LIMIT = 40;

    t_clt_result expected_results[$];
    int          reports;

    // Local copy of the parser state.
    logic       cmd_open;
    int         cmds_closed;
    int         word_count;
    logic       in_word;
    logic       lone_amp;
    logic       pipe_error;
    logic [7:0] line_pos;
    logic       last_bg;

    // Return the parser to its idle state, as after reset or an end marker.
    task automatic clear_parser();
        cmd_open    = 1'b0;
        cmds_closed = 0;
        word_count  = 0;
        in_word     = 1'b0;
        lone_amp    = 1'b0;
        pipe_error  = 1'b0;
        line_pos    = '0;
        last_bg     = 1'b0;
    endtask

    function automatic logic is_whitespace(input logic [7:0] ch);
        return ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR);
    endfunction

    // Close the open command. A final word that is a lone ampersand is
    // dropped from the count and marks the command as background.
    task automatic close_command(inout t_clt_result r);
        int   count;
        logic bg;
        count = word_count;
        bg    = (count > 0) && lone_amp;
        if (bg) begin
            count--;
        end
        last_bg             = bg;
        r.command_closed    = 1'b1;
        r.closed_index      = 3'(cmds_closed);
        r.closed_word_count = 4'(count);
        r.closed_background = bg;
        cmds_closed++;
        cmd_open   = 1'b0;
        in_word    = 1'b0;
        word_count = 0;
        lone_amp   = 1'b0;
    endtask

    // Work out the result of one request and advance the parser state.
    task automatic tokenize_request(input logic kind, input logic [7:0] ch,
                                    output t_clt_result r);
        r          = '0;
        r.position = line_pos;
        if (kind == KIND_END) begin
            r.role = ROLE_END;
            // After a pipe error the line reports no commands at all.
            if (!pipe_error) begin
                if (cmd_open) begin
                    close_command(r);
                end
                r.command_total   = 4'(cmds_closed);
                r.line_background = last_bg;
            end
            clear_parser();
        end else begin
            if (line_pos < POS_LIMIT) begin
                line_pos++;
            end
            // Bytes after an error or past the command limit are ignored.
            if (!pipe_error && cmds_closed < MAX_COMMANDS) begin
                if (is_whitespace(ch)) begin
                    // Whitespace opens a command too, possibly an empty one.
                    if (!cmd_open) begin
                        cmd_open   = 1'b1;
                        word_count = 0;
                        lone_amp   = 1'b0;
                    end
                    in_word = 1'b0;
                end else if (ch == CHAR_PIPE) begin
                    if (cmd_open && word_count > 0) begin
                        close_command(r);
                        r.role = ROLE_PIPE;
                    end else begin
                        pipe_error = 1'b1;
                        r.role     = ROLE_ERROR;
                    end
                end else if (in_word) begin
                    lone_amp        = 1'b0;
                    r.role          = ROLE_WORD_CONT;
                    r.command_index = 3'(cmds_closed);
                    r.word_index    = 4'(word_count - 1);
                end else begin
                    // A word start once the command holds MAX_WORDS - 1 words closes it first.
                    if (cmd_open && word_count >= MAX_WORDS - 1) begin
                        close_command(r);
                    end
                    if (cmds_closed < MAX_COMMANDS) begin
                        if (!cmd_open) begin
                            cmd_open   = 1'b1;
                            word_count = 0;
                        end
                        word_count++;
                        in_word         = 1'b1;
                        lone_amp        = (ch == CHAR_AMP);
                        r.role          = ROLE_WORD_START;
                        r.command_index = 3'(cmds_closed);
                        r.word_index    = 4'(word_count - 1);
                    end
                end
            end
        end
    endtask

    function automatic int field_differs(input string name, input int unsigned want,
                                         input int unsigned seen);
        if (want == seen) begin
            return 0;
        end
        if (reports < REPORT_LIMIT) begin
            reports++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
        end
        return 1;
    endfunction

    // Predict on every accepted request, compare on every accepted result.
    always @(posedge i_clk) begin : monitor
        t_clt_result want;
        t_clt_result seen;
        int          diffs;
        if (!i_rst_n) begin
            clear_parser();
            expected_results.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                tokenize_request(i_req_kind, i_req_char, want);
                expected_results.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                seen = {i_role, i_position, i_command_index, i_word_index,
                        i_command_closed, i_closed_index, i_closed_word_count,
                        i_closed_background, i_command_total, i_line_background};
                o_results++;
                if (seen.command_closed) begin
                    o_closes++;
                end
                if (seen.closed_background) begin
                    o_background++;
                end
                if (seen.role == ROLE_ERROR) begin
                    o_errors++;
                end
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result with role %0d arrived with none expected",
                             $time, i_role);
                end else begin
                    want  = expected_results.pop_front();
                    diffs = field_differs("role", want.role, seen.role)
                          + field_differs("position", want.position, seen.position)
                          + field_differs("command_index", want.command_index,
                                          seen.command_index)
                          + field_differs("word_index", want.word_index, seen.word_index)
                          + field_differs("command_closed", want.command_closed,
                                          seen.command_closed)
                          + field_differs("closed_index", want.closed_index,
                                          seen.closed_index)
                          + field_differs("closed_word_count", want.closed_word_count,
                                          seen.closed_word_count)
                          + field_differs("closed_background", want.closed_background,
                                          seen.closed_background)
                          + field_differs("command_total", want.command_total,
                                          seen.command_total)
                          + field_differs("line_background", want.line_background,
                                          seen.line_background);
                    if (diffs != 0) begin
                        o_mismatches++;
                    end
                end
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tokenizer core testbench
// Feeds the core a short set of hand-written lines covering the corner cases,
// then about fifteen hundred requests of random command lines: mostly
// well-formed pipelines with random words, plus lines at the word and command
// limits, one line long enough to saturate the position, and noise lines.
// Both sides stall at random; the checker beside the core judges results.
// ---------------------------------------------------------------------------
module tb_top;
    import clt_pkg::*;

    localparam int RANDOM_REQUESTS = 1500;
    localparam int STALL_LIMIT     = 500;
    localparam int DRAIN_CYCLES    = 20;
    localparam int IDLE_PERCENT    = 7;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_kind  = KIND_BYTE;
    logic [7:0] req_char  = 8'h00;
    logic       res_ready = 1'b0;
    logic       idle_on   = 1'b1;

    logic       req_ready;
    logic       res_valid;
    logic [2:0] res_role;
    logic [7:0] res_position;
    logic [2:0] res_command_index;
    logic [3:0] res_word_index;
    logic       res_command_closed;
    logic [2:0] res_closed_index;
    logic [3:0] res_closed_word_count;
    logic       res_closed_background;
    logic [3:0] res_command_total;
    logic       res_line_background;

    int mismatches;
    int outstanding;
    int results;
    int closes;
    int background;
    int errors;
    int stall_cycles;
    int requests_sent;
    int lines_sent;

    logic [8:0] line_items[$];

    // Hand-written lines: extreme bytes, a background close by pipe, an empty
    // command hit by a pipe, an empty line, a pipe with no command, a double
    // ampersand word, a blank-only command and a background last command.
    logic [8:0] opening_seq [25] = '{
        {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'hFF}, {KIND_BYTE, CHAR_TAB},
        {KIND_BYTE, CHAR_AMP}, {KIND_BYTE, CHAR_SPACE}, {KIND_BYTE, CHAR_PIPE},
        {KIND_BYTE, 8'h0B}, {KIND_BYTE, CHAR_PIPE}, {KIND_BYTE, "z"},
        {KIND_END, 8'h00},
        {KIND_END, 8'hFF},
        {KIND_BYTE, CHAR_PIPE}, {KIND_END, 8'h00},
        {KIND_BYTE, "a"}, {KIND_BYTE, CHAR_SPACE}, {KIND_BYTE, CHAR_AMP},
        {KIND_BYTE, CHAR_AMP}, {KIND_BYTE, CHAR_CR}, {KIND_END, 8'h00},
        {KIND_BYTE, CHAR_SPACE}, {KIND_END, 8'h00},
        {KIND_BYTE, "a"}, {KIND_BYTE, CHAR_SPACE}, {KIND_BYTE, CHAR_AMP},
        {KIND_END, 8'h00}
    };

    command_line_tokenizer_core uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (req_valid),
        .o_ready             (req_ready),
        .i_kind              (req_kind),
        .i_char_in           (req_char),
        .o_valid             (res_valid),
        .i_ready             (res_ready),
        .o_role              (res_role),
        .o_position          (res_position),
        .o_command_index     (res_command_index),
        .o_word_index        (res_word_index),
        .o_command_closed    (res_command_closed),
        .o_closed_index      (res_closed_index),
        .o_closed_word_count (res_closed_word_count),
        .o_closed_background (res_closed_background),
        .o_command_total     (res_command_total),
        .o_line_background   (res_line_background)
    );

    tokenizer_checker u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_req_valid         (req_valid),
        .i_req_ready         (req_ready),
        .i_req_kind          (req_kind),
        .i_req_char          (req_char),
        .i_res_valid         (res_valid),
        .i_res_ready         (res_ready),
        .i_role              (res_role),
        .i_position          (res_position),
        .i_command_index     (res_command_index),
        .i_word_index        (res_word_index),
        .i_command_closed    (res_command_closed),
        .i_closed_index      (res_closed_index),
        .i_closed_word_count (res_closed_word_count),
        .i_closed_background (res_closed_background),
        .i_command_total     (res_command_total),
        .i_line_background   (res_line_background),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding),
        .o_results           (results),
        .o_closes            (closes),
        .o_background        (background),
        .o_errors            (errors)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random back-pressure unless idling is switched off.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            res_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Count cycles in which neither channel moves a request or a result.
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("command_line_tokenizer_core regression: fail");
        $finish;
    end

    // Offer one request, with an occasional idle cycle first, and hold it
    // until taken.
    task automatic send_request(input logic kind, input logic [7:0] ch);
        if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_kind  <= kind;
        req_char  <= ch;
        do @(posedge clk); while (!req_ready);
        requests_sent++;
    endtask

    // Any byte that is neither whitespace nor a pipe.
    function automatic logic [7:0] pick_word_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CHAR_PIPE || b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)) begin
            b = b ^ 8'h40;
        end
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        int idx;
        idx = $urandom_range(5);
        return (idx == 5) ? CHAR_SPACE : CHAR_TAB + 8'(idx);
    endfunction

    // Build a pipeline of commands. The last command can be forced over the
    // word limit; now and then a command is left empty to provoke an error.
    task automatic build_line(input int n_cmds, input int min_words, input int max_words,
                              input int max_len, input logic full_last);
        int n_words;
        int len;
        for (int c = 0; c < n_cmds; c++) begin
            if ($urandom_range(3) == 0) begin
                line_items.push_back({KIND_BYTE, pick_blank()});
            end
            if (full_last && c == n_cmds - 1) begin
                n_words = $urandom_range(MAX_WORDS + 1, MAX_WORDS - 1);
            end else if ($urandom_range(11) == 0) begin
                n_words = 0;
            end else begin
                n_words = $urandom_range(max_words, min_words);
            end
            for (int w = 0; w < n_words; w++) begin
                if (w > 0) begin
                    repeat ($urandom_range(2, 1)) line_items.push_back({KIND_BYTE, pick_blank()});
                end
                if (w == n_words - 1 && $urandom_range(4) == 0) begin
                    line_items.push_back({KIND_BYTE, CHAR_AMP});
                end else begin
                    len = full_last ? 1 : $urandom_range(max_len, 1);
                    for (int k = 0; k < len; k++) begin
                        if (k == 0 && $urandom_range(9) == 0) begin
                            line_items.push_back({KIND_BYTE, CHAR_AMP});
                        end else begin
                            line_items.push_back({KIND_BYTE, pick_word_byte()});
                        end
                    end
                end
            end
            if ($urandom_range(3) == 0) begin
                line_items.push_back({KIND_BYTE, pick_blank()});
            end
            if (c < n_cmds - 1) begin
                line_items.push_back({KIND_BYTE, CHAR_PIPE});
            end
        end
    endtask

    // Unstructured bytes, weighted toward blanks, pipes and ampersands.
    task automatic build_noise(input int len);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(7))
                0, 1:    b = pick_blank();
                2:       b = CHAR_PIPE;
                3:       b = CHAR_AMP;
                default: b = 8'($urandom_range(255));
            endcase
            line_items.push_back({KIND_BYTE, b});
        end
    endtask

    task automatic send_line();
        foreach (line_items[k]) begin
            send_request(line_items[k][8], line_items[k][7:0]);
        end
        send_request(KIND_END, 8'($urandom_range(255)));
        line_items.delete();
        lines_sent++;
    endtask

    initial begin
        logic long_done;
        int   shape;
        long_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines first.
        foreach (opening_seq[k]) begin
            send_request(opening_seq[k][8], opening_seq[k][7:0]);
            if (opening_seq[k][8] == KIND_END) begin
                lines_sent++;
            end
        end

        // Random lines; a stretch in the middle runs with no idling at all.
        while (requests_sent < RANDOM_REQUESTS) begin
            idle_on <= !(requests_sent >= 600 && requests_sent < 900);
            shape = $urandom_range(99);
            if (!long_done && requests_sent >= 300) begin
                build_line(4, 15, 15, 7, 1'b0);
                long_done = 1'b1;
            end else if (shape < 60) begin
                build_line($urandom_range(3, 1), 1, 4, 4, 1'b0);
            end else if (shape < 70) begin
                build_line($urandom_range(10, 7), 1, 2, 2, 1'b0);
            end else if (shape < 78) begin
                build_line($urandom_range(2, 1), 13, 15, 1, 1'b1);
            end else if (shape < 84) begin
                build_line(MAX_COMMANDS, 1, 1, 2, 1'b1);
            end else begin
                build_noise($urandom_range(24));
            end
            send_line();
        end
        req_valid <= 1'b0;
        idle_on   <= 1'b1;

        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d lines in %0d requests: %0d results checked,", lines_sent,
                 requests_sent, results);
        $display("%0d command closes (%0d background) and %0d pipe errors.", closes,
                 background, errors);
        if (outstanding != 0) begin
            $display("%0t: %0d expected results never arrived", $time, outstanding);
        end
        if (mismatches == 0 && outstanding == 0) begin
            $display("command_line_tokenizer_core regression: pass");
        end else begin
            $display("command_line_tokenizer_core regression: fail");
        end
        $finish;
    end

endmodule
